FILE: src/sida_pkg.sv
// Shared types, codes and field widths for the sparse insert/delete array.
`default_nettype none

package sida_pkg;

  // Default number of array slots.
  localparam int CAPACITY_DEF = 32;

  // Field widths fixed by the word formats.
  localparam int OP_W    = 1;
  localparam int POS_W   = 6;
  localparam int VAL_W   = 32;
  localparam int STAT_W  = 2;
  localparam int LEN_W   = 6;
  localparam int IDX_W   = 5;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_INSERT = 1'b0;
  localparam logic [OP_W-1:0] OP_REMOVE = 1'b1;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_ZERO  = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
  localparam logic [STAT_W-1:0] ST_ROOM  = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // capture the input word
    logic exec;     // apply the operation and stage the results
    logic advance;  // step to the next result word
  } sida_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;     // the presented result word is the final one
  } sida_stat_t;

endpackage

`default_nettype wire

FILE: src/sida_chan_if.sv
// Handshake channel interfaces for the input and result words.
`default_nettype none

interface sida_in_if;
  import sida_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         opcode;
  logic [POS_W-1:0]        position;
  logic signed [VAL_W-1:0] item_value;

  modport source (output valid, output opcode, output position, output item_value,
                  input ready);
  modport sink (input valid, input opcode, input position, input item_value,
                output ready);
endinterface

interface sida_out_if;
  import sida_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [STAT_W-1:0]       status;
  logic [LEN_W-1:0]        array_length;
  logic [IDX_W-1:0]        element_index;
  logic signed [VAL_W-1:0] element_value;
  logic                    is_empty;
  logic                    last;

  modport source (output valid, output status, output array_length,
                  output element_index, output element_value, output is_empty,
                  output last, input ready);
  modport sink (input valid, input status, input array_length,
                input element_index, input element_value, input is_empty,
                input last, output ready);
endinterface

`default_nettype wire

FILE: src/sida_ctrl.sv
// Controller state machine: accept a word, execute it, then emit its results.
`default_nettype none

module sida_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  input  wire sida_pkg::sida_stat_t stat,
  output sida_pkg::sida_cmd_t       cmd
);
  import sida_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // Handshake outputs follow the state directly.
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_EMIT);

  // Commands to the datapath.
  always_comb begin
    cmd.load    = in_valid && in_ready;
    cmd.exec    = (state_r == S_EXEC);
    cmd.advance = out_valid && out_ready && !stat.last;
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_ready && stat.last) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // An executed word always leads to result words.
  a_exec_then_emit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EXEC |=> state_r == S_EMIT)
    else $error("execute cycle not followed by emission");

  // Taking the final result word returns the controller to idle.
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && stat.last |=> state_r == S_IDLE)
    else $error("final result word did not end the operation");

  // No new word is taken while results are pending.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == S_EXEC && !in_ready)
    else $error("input accepted while an operation is in flight");

endmodule

`default_nettype wire

FILE: src/sida_dpath.sv
// Datapath: slot chain with per-slot shift logic, decode, and result shift-out stage.
`default_nettype none

module sida_dpath #(
  parameter int CAPACITY = sida_pkg::CAPACITY_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire sida_pkg::sida_cmd_t               cmd,
  output sida_pkg::sida_stat_t                   stat,
  input  wire logic [sida_pkg::OP_W-1:0]         in_opcode,
  input  wire logic [sida_pkg::POS_W-1:0]        in_position,
  input  wire logic signed [sida_pkg::VAL_W-1:0] in_item_value,
  output logic [sida_pkg::STAT_W-1:0]            out_status,
  output logic [sida_pkg::LEN_W-1:0]             out_array_length,
  output logic [sida_pkg::IDX_W-1:0]             out_element_index,
  output logic signed [sida_pkg::VAL_W-1:0]      out_element_value,
  output logic                                   out_is_empty,
  output logic                                   out_last
);
  import sida_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int LW = ((CW > POS_W) ? CW : POS_W) + 1;

  // Captured input word.
  logic [OP_W-1:0]  op_r;
  logic [POS_W-1:0] pos_r;
  logic [VAL_W-1:0] val_r;

  // Slot chain and length.
  logic [VAL_W-1:0] cells_r   [CAPACITY];
  logic [VAL_W-1:0] cells_nxt [CAPACITY];
  logic [VAL_W-1:0] below_w   [CAPACITY];
  logic [VAL_W-1:0] above_w   [CAPACITY];
  logic [CW-1:0]    count_r;
  logic [CW-1:0]    count_nxt;

  // Result shift-out stage.
  logic [VAL_W-1:0]  shadow_r [CAPACITY];
  logic [IW-1:0]     idx_r;
  logic [STAT_W-1:0] status_r;
  logic              single_r;

  // Decode signals.
  logic [LW-1:0]       pos_ext;
  logic [LW-1:0]       cnt_ext;
  logic [LW-1:0]       newlen;
  logic                pos_in;
  logic [CAPACITY-1:0] slot_hit;
  logic                slot_zero;
  logic                do_fill;
  logic                do_ins;
  logic                do_rem;
  logic [STAT_W-1:0]   err_code;

  assign pos_ext   = LW'(pos_r);
  assign cnt_ext   = LW'(count_r);
  assign pos_in    = pos_ext < cnt_ext;
  assign newlen    = pos_in ? (cnt_ext + LW'(1)) : (pos_ext + LW'(1));
  assign slot_zero = |slot_hit;

  // Neighbor taps of each slot; the chain ends read as zero.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_tap
    assign slot_hit[i] = (pos_ext == LW'(i)) && (cells_r[i] == '0);
    if (i > 0) begin : g_below
      assign below_w[i] = cells_r[i-1];
    end else begin : g_below0
      assign below_w[i] = '0;
    end
    if (i < CAPACITY - 1) begin : g_above
      assign above_w[i] = cells_r[i+1];
    end else begin : g_top
      assign above_w[i] = '0;
    end
  end

  // Decide the operation and any error.
  always_comb begin
    do_fill  = 1'b0;
    do_ins   = 1'b0;
    do_rem   = 1'b0;
    err_code = ST_OK;
    unique case (op_r)
      OP_INSERT: begin
        if (val_r == '0) begin
          err_code = ST_ZERO;
        end else if (pos_in && slot_zero) begin
          do_fill = 1'b1;
        end else if (newlen > LW'(CAPACITY)) begin
          err_code = ST_ROOM;
        end else begin
          do_ins = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (!pos_in) begin
          err_code = ST_RANGE;
        end else begin
          do_rem = 1'b1;
        end
      end
      default: begin
        err_code = ST_OK;
      end
    endcase
  end

  // New length.
  always_comb begin
    count_nxt = count_r;
    if (do_ins) begin
      count_nxt = CW'(newlen);
    end else if (do_rem) begin
      count_nxt = count_r - CW'(1);
    end
  end

  // Per-slot update: fill, open a gap above the position, or close it.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cells_nxt[i] = cells_r[i];
      if ((do_fill || do_ins) && (pos_ext == LW'(i))) begin
        cells_nxt[i] = val_r;
      end else if (do_ins && (LW'(i) > pos_ext)) begin
        cells_nxt[i] = below_w[i];
      end else if (do_rem && (LW'(i) >= pos_ext)) begin
        cells_nxt[i] = above_w[i];
      end
    end
  end

  // Input capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_opcode;
      pos_r <= in_position;
      val_r <= in_item_value;
    end
  end

  // Slot chain and length; both clear on reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CAPACITY; i++) begin
        cells_r[i] <= '0;
      end
      count_r <= '0;
    end else if (cmd.exec) begin
      for (int i = 0; i < CAPACITY; i++) begin
        cells_r[i] <= cells_nxt[i];
      end
      count_r <= count_nxt;
    end
  end

  // Result stage: load the updated array, then shift one word per handshake.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      for (int i = 0; i < CAPACITY; i++) begin
        shadow_r[i] <= cells_nxt[i];
      end
      idx_r    <= '0;
      status_r <= err_code;
      single_r <= (err_code != ST_OK) || (count_nxt == '0);
    end else if (cmd.advance) begin
      for (int i = 0; i < CAPACITY - 1; i++) begin
        shadow_r[i] <= shadow_r[i+1];
      end
      shadow_r[CAPACITY-1] <= '0;
      idx_r <= idx_r + IW'(1);
    end
  end

  // Result word fields.
  assign out_status        = status_r;
  assign out_array_length  = LEN_W'(count_r);
  assign out_element_index = single_r ? '0 : IDX_W'(idx_r);
  assign out_element_value = single_r ? '0 : shadow_r[0];
  assign out_is_empty      = single_r && (status_r == ST_OK);
  assign out_last          = single_r || ((CW'(idx_r) + CW'(1)) == count_r);
  assign stat.last         = out_last;

  // The length never exceeds the number of slots.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("array length beyond capacity");

  // A rejected operation leaves the length unchanged.
  a_err_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && (err_code != ST_OK) |=> $stable(count_r))
    else $error("length changed by a rejected operation");

  // The first slot past the end of the array always holds zero.
  a_tail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r < CW'(CAPACITY)) |-> (cells_r[IW'(count_r)] == '0))
    else $error("nonzero slot past the end of the array");

endmodule

`default_nettype wire

FILE: src/sparse_insert_delete_array.sv
// A word accepted in IDLE is executed in the EXEC state; its first result shows in the EMIT state.
// The result shift-out stage presents one element per cycle while the sink is ready.
// Only one word is in flight: input is ready again after the final result word is taken.
// Reset (synchronous, active low) clears all slots and the length to zero at once.
// Top level: ordered sparse array with insert, fill and remove; emits the array or an error word.
`default_nettype none

module sparse_insert_delete_array #(
  parameter int CAPACITY = sida_pkg::CAPACITY_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  sida_in_if.sink   in_ch,
  sida_out_if.source out_ch
);
  import sida_pkg::*;

  sida_cmd_t  cmd;
  sida_stat_t stat;

  // Sequencing.
  sida_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Storage and data handling.
  sida_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_opcode         (in_ch.opcode),
    .in_position       (in_ch.position),
    .in_item_value     (in_ch.item_value),
    .out_status        (out_ch.status),
    .out_array_length  (out_ch.array_length),
    .out_element_index (out_ch.element_index),
    .out_element_value (out_ch.element_value),
    .out_is_empty      (out_ch.is_empty),
    .out_last          (out_ch.last)
  );

endmodule

`default_nettype wire

FILE: tb/sparse_insert_delete_array_test.sv
// Self-checking testbench for the sparse insert/delete array with its own array predictor.
`default_nettype none

module sparse_insert_delete_array_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sida_pkg::*;

  localparam int CAP          = CAPACITY_DEF;
  localparam int RANDOM_WORDS = 400;
  localparam int STALL_LIMIT  = 2000;

  // One input word and one result word.
  typedef struct {
    logic [OP_W-1:0]         opcode;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] item_value;
  } op_word_t;

  typedef struct {
    logic [STAT_W-1:0]       status;
    logic [LEN_W-1:0]        array_length;
    logic [IDX_W-1:0]        element_index;
    logic signed [VAL_W-1:0] element_value;
    logic                    is_empty;
    logic                    last;
  } result_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  sida_in_if  in_ch();
  sida_out_if out_ch();

  sparse_insert_delete_array #(.CAPACITY(CAP)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow copy of the array and its length.
  logic signed [VAL_W-1:0] slot_vals [CAP];
  int slot_len = 0;

  op_word_t     pending_words[$];
  result_word_t expected_words[$];

  int   mismatches = 0;
  int   words_taken = 0;
  int   idle_cycles = 0;
  logic in_taken = 1'b0;
  logic quiet;

  // A long stretch with no idling on either side.
  assign quiet = (words_taken >= 200) && (words_taken < 290);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    for (int i = 0; i < CAP; i++) slot_vals[i] = '0;
  end

  function automatic void push_result(logic [STAT_W-1:0] st, int len, int idx,
                                      logic signed [VAL_W-1:0] val, logic emp, logic lst);
    result_word_t r;
    r.status        = st;
    r.array_length  = len[LEN_W-1:0];
    r.element_index = idx[IDX_W-1:0];
    r.element_value = val;
    r.is_empty      = emp;
    r.last          = lst;
    expected_words.push_back(r);
  endfunction

  // Apply one word to the shadow array and queue the words it should emit.
  function automatic void apply_array_op(op_word_t w);
    int p;
    int new_len;
    p = w.position;
    if (w.opcode == OP_INSERT) begin
      if (w.item_value == 0) begin
        push_result(ST_ZERO, slot_len, 0, '0, 1'b0, 1'b1);
        return;
      end
      if (p < slot_len && slot_vals[p] == 0) begin
        slot_vals[p] = w.item_value;
      end else begin
        new_len = (p < slot_len) ? slot_len + 1 : p + 1;
        if (new_len > CAP) begin
          push_result(ST_ROOM, slot_len, 0, '0, 1'b0, 1'b1);
          return;
        end
        for (int i = new_len - 1; i > p; i--) slot_vals[i] = slot_vals[i-1];
        slot_vals[p] = w.item_value;
        slot_len = new_len;
      end
    end else begin
      if (p >= slot_len) begin
        push_result(ST_RANGE, slot_len, 0, '0, 1'b0, 1'b1);
        return;
      end
      for (int i = p; i + 1 < slot_len; i++) slot_vals[i] = slot_vals[i+1];
      slot_vals[slot_len-1] = '0;
      slot_len--;
    end
    // A good operation dumps the whole array, or one empty marker.
    if (slot_len == 0) begin
      push_result(ST_OK, 0, 0, '0, 1'b1, 1'b1);
    end else begin
      for (int i = 0; i < slot_len; i++)
        push_result(ST_OK, slot_len, i, slot_vals[i], 1'b0, i == slot_len - 1);
    end
  endfunction

  function automatic void check_field(string name, logic [VAL_W-1:0] want,
                                      logic [VAL_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
    end
  endfunction

  function automatic void queue_word(logic [OP_W-1:0] op, int pos, logic [VAL_W-1:0] val);
    op_word_t w;
    w.opcode     = op;
    w.position   = pos[POS_W-1:0];
    w.item_value = val;
    pending_words.push_back(w);
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    int s;
    s = $urandom_range(99);
    if (s < 3) return '0;
    if (s < 6) return 32'h8000_0000;
    if (s < 9) return 32'h7fff_ffff;
    if (s < 11) return 32'hffff_ffff;
    return $urandom;
  endfunction

  // Hold off until every expected word has come back.
  task automatic drain_all();
    while (pending_words.size() != 0 || in_ch.valid || expected_words.size() != 0)
      @(posedge clk);
  endtask

  // Input side: predict each accepted word.
  always @(posedge clk) begin
    op_word_t w;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      w.opcode     = in_ch.opcode;
      w.position   = in_ch.position;
      w.item_value = in_ch.item_value;
      apply_array_op(w);
      words_taken++;
    end
    in_taken <= rst_n && in_ch.valid && in_ch.ready;
  end

  // Driver: present the next pending word, with random gaps.
  always @(negedge clk) begin
    op_word_t w;
    if (rst_n && (!in_ch.valid || in_taken)) begin
      if (pending_words.size() != 0 && (quiet || $urandom_range(99) >= 6)) begin
        w = pending_words.pop_front();
        in_ch.valid      <= 1'b1;
        in_ch.opcode     <= w.opcode;
        in_ch.position   <= w.position;
        in_ch.item_value <= w.item_value;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result side backpressure.
  always @(negedge clk) begin
    out_ch.ready <= quiet || ($urandom_range(99) >= 6);
  end

  // Monitor: compare each result word with the oldest expectation.
  always @(posedge clk) begin
    result_word_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_words.size() == 0) begin
        mismatches++;
        $error("unexpected result word: status %0d, index %0d, value 0x%0h",
               out_ch.status, out_ch.element_index, out_ch.element_value);
      end else begin
        want = expected_words.pop_front();
        check_field("status", want.status, out_ch.status);
        check_field("array_length", want.array_length, out_ch.array_length);
        check_field("element_index", want.element_index, out_ch.element_index);
        check_field("element_value", want.element_value, out_ch.element_value);
        check_field("is_empty", want.is_empty, out_ch.is_empty);
        check_field("last", want.last, out_ch.last);
      end
    end
  end

  // Watchdog on cycles in which no word moves on either channel.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus.
  initial begin
    int cnt;
    int r;
    int s;
    int p;
    in_ch.valid      = 1'b0;
    in_ch.opcode     = OP_INSERT;
    in_ch.position   = '0;
    in_ch.item_value = '0;
    out_ch.ready     = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed: errors on an empty array, the empty marker, gaps, fills and a full array.
    queue_word(OP_REMOVE, 0, 32'hdead_beef);
    queue_word(OP_INSERT, 0, 32'h0);
    queue_word(OP_INSERT, 0, 32'h1);
    queue_word(OP_INSERT, 0, 32'h0);
    queue_word(OP_REMOVE, 0, 32'h0);
    queue_word(OP_INSERT, 63, 32'h1);
    queue_word(OP_INSERT, 32, 32'h5);
    queue_word(OP_INSERT, 3, 32'h7fff_ffff);
    queue_word(OP_INSERT, 1, 32'h8000_0000);
    queue_word(OP_INSERT, 1, 32'hffff_ffff);
    queue_word(OP_INSERT, 0, 32'h5555_5555);
    queue_word(OP_INSERT, 6, 32'haaaa_aaaa);
    queue_word(OP_REMOVE, 7, 32'h1234_5678);
    queue_word(OP_REMOVE, 0, 32'hffff_ffff);
    queue_word(OP_REMOVE, 5, 32'h0);
    queue_word(OP_INSERT, 31, 32'h7);
    queue_word(OP_INSERT, 1, 32'h9);
    queue_word(OP_INSERT, 10, 32'hb);
    queue_word(OP_INSERT, 31, 32'h3);
    queue_word(OP_INSERT, 40, 32'h1);
    queue_word(OP_REMOVE, 31, 32'h0);
    queue_word(OP_REMOVE, 63, 32'h0);
    drain_all();

    // Random: mostly legal inserts and removes around the current length.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      while (pending_words.size() != 0) @(posedge clk);
      if (n == RANDOM_WORDS / 2) drain_all();
      cnt = slot_len;
      r = $urandom_range(99);
      if (r < 4) begin
        queue_word(OP_W'($urandom_range(1)), $urandom_range(63), pick_value());
      end else if (cnt > 0 && (r < 40 || (cnt > 24 && r < 70))) begin
        queue_word(OP_REMOVE, $urandom_range(cnt - 1), $urandom);
      end else if (r < 42) begin
        queue_word(OP_REMOVE, cnt + $urandom_range(3), $urandom);
      end else begin
        s = $urandom_range(9);
        if (s < 6) p = $urandom_range(cnt);
        else if (s < 9) p = cnt + $urandom_range(4);
        else p = $urandom_range(63, 32);
        queue_word(OP_INSERT, p, pick_value());
      end
    end

    // Let everything come back, then allow for a full array dump more.
    while (pending_words.size() != 0 || in_ch.valid) @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (CAP + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
